### rtl/core/sotq_pkg.sv
// Package: shared constants, codes and state type of the sorted timer queue.
`timescale 1ns / 1ps

package sotq_pkg;

  // Default sizes
  localparam int unsigned SLOTS_DEF     = 64;
  localparam int unsigned TIME_BITS_DEF = 47;

  // Field widths fixed by the interface
  localparam int unsigned OP_W     = 2;
  localparam int unsigned IVL_W    = 16;
  localparam int unsigned ID_W     = 6;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned OUT_W    = 32;

  // Register reset values and the delay saturation value
  localparam logic [CFG_W-1:0] MIN_IVL_RST   = 16'd50;
  localparam logic [CFG_W-1:0] MAX_IVL_RST   = 16'd10000;
  localparam logic [CFG_W-1:0] IDLE_DLY_RST  = 16'd5000;
  localparam logic [DELAY_W-1:0] DELAY_SAT   = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_IVL  = 2'd0,
    CFG_MAX_IVL  = 2'd1,
    CFG_IDLE_DLY = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_idx_e;

  // Operation codes; result kinds use the same numbering plus fired
  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_QUERY   = 2'd2,
    OP_PROCESS = 2'd3
  } op_e;

  typedef enum logic [OP_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_REM   = 2'd1,
    KIND_DELAY = 2'd2,
    KIND_FIRED = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE,
    S_INS_RD,
    S_INS_EX,
    S_INS_CMP,
    S_INS_PUT,
    S_RM_RD,
    S_RM_CHK,
    S_HEAD_RD,
    S_HEAD_EX,
    S_HEAD_CMP,
    S_OUT
  } state_e;

endpackage

### rtl/core/sotq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sotq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sorted_oneshot_timer_queue.sv
// Top level: sorted one-shot timer queue with add, remove, query and process.
`timescale 1ns / 1ps

// Usage
//   Commands enter on the s_axis channel (opcode, interval, id, current time)
//   and replies leave on the m_axis channel. Add, remove and query each give
//   one reply with tlast set. Process gives one item per fired timer, in
//   expiry order, tlast on the final one, and no item when nothing is due.
//   Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// Timing
//   One command is worked at a time; s_axis_tready is high only when idle.
//   Order ids live in one RAM by position, expiry times in a second RAM by
//   id, both with registered read data; every walk step is a read, then a
//   compare and a write.
//   Add: a free id scan, then a walk that moves later entries up by one.
//   Remove: a walk over the active entries. Query: one head read.
//   Process: head checks, plus per fired timer one reply and a remove
//   walk.
// Reset clears all timers and loads the register defaults; RAM contents need
// no clearing. A stalled receiver holds the last reply in the output register;
// the sequencer waits in its reply state until that register frees up.

module sorted_oneshot_timer_queue
  import sotq_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = SLOTS_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF,
  parameter int unsigned IN_W        = ((OP_W + IVL_W + ID_W + TIME_BITS + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // commands
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,  // opcode, interval_ms, timer_id, now_ms
  // replies
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,  // kind, status, result_id, delay_ms
  output logic                 m_axis_tlast
);

  localparam int unsigned IW = $clog2(TIMER_SLOTS);
  localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned EW = TIME_BITS + 1;
  localparam int unsigned NOW_LO = OP_W + IVL_W + ID_W;

  // Input field split
  logic [OP_W-1:0]      in_op;
  logic [IVL_W-1:0]     in_ivl;
  logic [ID_W-1:0]      in_tid;
  logic [TIME_BITS-1:0] in_now;
  assign in_op  = s_axis_tdata[OP_W-1:0];
  assign in_ivl = s_axis_tdata[OP_W+IVL_W-1:OP_W];
  assign in_tid = s_axis_tdata[NOW_LO-1:OP_W+IVL_W];
  assign in_now = s_axis_tdata[NOW_LO+TIME_BITS-1:NOW_LO];

  // Registers
  state_e               state_q, state_d;
  logic [CFG_W-1:0]     min_ivl_q, max_ivl_q, idle_dly_q;
  op_e                  op_q, op_d;
  logic [IVL_W-1:0]     ivl_q, ivl_d;
  logic [ID_W-1:0]      tid_q, tid_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic                 found_q, found_d;
  logic                 pend_q, pend_d;
  logic [IW-1:0]        pend_id_q, pend_id_d;
  logic [IW-1:0]        cur_id_q, cur_id_d;
  logic [IW-1:0]        new_id_q, new_id_d;
  logic [EW-1:0]        new_exp_q, new_exp_d;
  logic [TIMER_SLOTS-1:0] valid_q, valid_d;
  // pending reply
  kind_e                e_kind_q, e_kind_d;
  logic                 e_status_q, e_status_d;
  logic [ID_W-1:0]      e_id_q, e_id_d;
  logic [DELAY_W-1:0]   e_delay_q, e_delay_d;
  logic                 e_last_q, e_last_d;
  // output register
  logic                 out_valid_q;
  logic [OUT_W-1:0]     out_data_q;
  logic                 out_last_q;
  logic                 out_free, out_load;

  // RAM ports
  logic          ord_we, exp_we;
  logic [IW-1:0] ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic [IW-1:0] exp_waddr, exp_raddr;
  logic [EW-1:0] exp_rdata;

  sotq_ram #(.WIDTH(IW), .DEPTH(TIMER_SLOTS), .AW(IW)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  sotq_ram #(.WIDTH(EW), .DEPTH(TIMER_SLOTS), .AW(IW)) u_expiry_ram (
    .clk_i   (clk_i),
    .we_i    (exp_we),
    .waddr_i (exp_waddr),
    .wdata_i (new_exp_q),
    .raddr_i (exp_raddr),
    .rdata_o (exp_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_ivl_q  <= MIN_IVL_RST;
      max_ivl_q  <= MAX_IVL_RST;
      idle_dly_q <= IDLE_DLY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_IVL:  min_ivl_q  <= cfg_data_i;
        CFG_MAX_IVL:  max_ivl_q  <= cfg_data_i;
        CFG_IDLE_DLY: idle_dly_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Head compare helpers
  logic [EW-1:0] now_ext, diff;
  logic          due;
  logic [IW-1:0] idx_lo, idx_m1_lo;
  logic [CW-1:0] idx_m1;
  assign now_ext   = EW'(now_q);
  assign diff      = exp_rdata - now_ext;
  assign due       = exp_rdata <= now_ext;
  assign idx_m1    = idx_q - CW'(1);
  assign idx_lo    = idx_q[IW-1:0];
  assign idx_m1_lo = idx_m1[IW-1:0];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    ivl_d      = ivl_q;
    tid_d      = tid_q;
    now_d      = now_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    found_d    = found_q;
    pend_d     = pend_q;
    pend_id_d  = pend_id_q;
    cur_id_d   = cur_id_q;
    new_id_d   = new_id_q;
    new_exp_d  = new_exp_q;
    valid_d    = valid_q;
    e_kind_d   = e_kind_q;
    e_status_d = e_status_q;
    e_id_d     = e_id_q;
    e_delay_d  = e_delay_q;
    e_last_d   = e_last_q;
    ord_we     = 1'b0;
    ord_waddr  = idx_lo;
    ord_wdata  = cur_id_q;
    ord_raddr  = '0;
    exp_we     = 1'b0;
    exp_waddr  = new_id_q;
    exp_raddr  = ord_rdata;
    out_load   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = op_e'(in_op);
          tid_d   = in_tid;
          now_d   = in_now;
          idx_d   = '0;
          found_d = 1'b0;
          pend_d  = 1'b0;
          // clamp: the minimum test wins when the bounds cross
          if (in_ivl < min_ivl_q) begin
            ivl_d = min_ivl_q;
          end else if (in_ivl > max_ivl_q) begin
            ivl_d = max_ivl_q;
          end else begin
            ivl_d = in_ivl;
          end
          e_status_d = 1'b0;
          e_id_d     = '0;
          e_delay_d  = '0;
          e_last_d   = 1'b1;
          unique case (op_e'(in_op))
            OP_ADD: state_d = S_FREE;
            OP_REMOVE: begin
              if (({1'b0, in_tid} < 7'(TIMER_SLOTS)) && valid_q[in_tid[IW-1:0]]) begin
                state_d = S_RM_RD;
              end else begin
                e_kind_d   = KIND_REM;
                e_status_d = 1'b1;
                e_id_d     = in_tid;
                state_d    = S_OUT;
              end
            end
            OP_QUERY: begin
              if (cnt_q == '0) begin
                e_kind_d  = KIND_DELAY;
                e_delay_d = idle_dly_q;
                state_d   = S_OUT;
              end else begin
                state_d = S_HEAD_RD;
              end
            end
            default: state_d = S_HEAD_RD;
          endcase
        end
      end

      // lowest free id, one slot a cycle
      S_FREE: begin
        if (idx_q == CW'(TIMER_SLOTS)) begin
          e_kind_d   = KIND_ADD;
          e_status_d = 1'b1;
          e_id_d     = '0;
          state_d    = S_OUT;
        end else if (!valid_q[idx_lo]) begin
          new_id_d  = idx_lo;
          new_exp_d = EW'(now_q) + EW'(ivl_q);
          idx_d     = cnt_q;
          state_d   = S_INS_RD;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      // walk down from the tail, moving later entries up by one
      S_INS_RD: begin
        if (idx_q == '0) begin
          state_d = S_INS_PUT;
        end else begin
          ord_raddr = idx_m1_lo;
          state_d   = S_INS_EX;
        end
      end

      S_INS_EX: begin
        cur_id_d  = ord_rdata;
        exp_raddr = ord_rdata;
        state_d   = S_INS_CMP;
      end

      S_INS_CMP: begin
        if (exp_rdata > new_exp_q) begin
          ord_we    = 1'b1;
          ord_waddr = idx_lo;
          ord_wdata = cur_id_q;
          idx_d     = idx_m1;
          state_d   = S_INS_RD;
        end else begin
          state_d = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        ord_we            = 1'b1;
        ord_waddr         = idx_lo;
        ord_wdata         = new_id_q;
        exp_we            = 1'b1;
        valid_d[new_id_q] = 1'b1;
        cnt_d             = cnt_q + CW'(1);
        e_kind_d          = KIND_ADD;
        e_status_d        = 1'b0;
        e_id_d            = ID_W'(new_id_q);
        state_d           = S_OUT;
      end

      // remove walk: find the target and close the gap behind it
      S_RM_RD: begin
        if (idx_q == cnt_q) begin
          valid_d[tid_q[IW-1:0]] = 1'b0;
          cnt_d                  = cnt_q - CW'(1);
          if (op_q == OP_REMOVE) begin
            e_kind_d   = KIND_REM;
            e_status_d = 1'b0;
            e_id_d     = tid_q;
            state_d    = S_OUT;
          end else begin
            state_d = S_HEAD_RD;
          end
        end else begin
          ord_raddr = idx_lo;
          state_d   = S_RM_CHK;
        end
      end

      S_RM_CHK: begin
        if (found_q) begin
          ord_we    = 1'b1;
          ord_waddr = idx_m1_lo;
          ord_wdata = ord_rdata;
        end
        if (ord_rdata == tid_q[IW-1:0]) begin
          found_d = 1'b1;
        end
        idx_d   = idx_q + CW'(1);
        state_d = S_RM_RD;
      end

      // earliest timer: order[0], then its expiry
      S_HEAD_RD: begin
        if (cnt_q == '0) begin
          if (pend_q) begin
            e_kind_d = KIND_FIRED;
            e_id_d   = ID_W'(pend_id_q);
            e_last_d = 1'b1;
            state_d  = S_OUT;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          ord_raddr = '0;
          state_d   = S_HEAD_EX;
        end
      end

      S_HEAD_EX: begin
        cur_id_d  = ord_rdata;
        exp_raddr = ord_rdata;
        state_d   = S_HEAD_CMP;
      end

      S_HEAD_CMP: begin
        if (op_q == OP_QUERY) begin
          e_kind_d = KIND_DELAY;
          if (due) begin
            e_delay_d = '0;
          end else if (diff > EW'(DELAY_SAT)) begin
            e_delay_d = DELAY_SAT;
          end else begin
            e_delay_d = diff[DELAY_W-1:0];
          end
          state_d = S_OUT;
        end else if (due) begin
          tid_d     = ID_W'(cur_id_q);
          pend_id_d = cur_id_q;
          idx_d     = '0;
          found_d   = 1'b0;
          if (pend_q) begin
            // the previous fired timer is not the final one
            e_kind_d = KIND_FIRED;
            e_id_d   = ID_W'(pend_id_q);
            e_last_d = 1'b0;
            state_d  = S_OUT;
          end else begin
            pend_d  = 1'b1;
            state_d = S_RM_RD;
          end
        end else if (pend_q) begin
          e_kind_d = KIND_FIRED;
          e_id_d   = ID_W'(pend_id_q);
          e_last_d = 1'b1;
          state_d  = S_OUT;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = e_last_q ? S_IDLE : S_RM_RD;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      valid_q <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      pend_q  <= pend_d;
      found_q <= found_d;
    end
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    ivl_q      <= ivl_d;
    tid_q      <= tid_d;
    now_q      <= now_d;
    idx_q      <= idx_d;
    pend_id_q  <= pend_id_d;
    cur_id_q   <= cur_id_d;
    new_id_q   <= new_id_d;
    new_exp_q  <= new_exp_d;
    e_kind_q   <= e_kind_d;
    e_status_q <= e_status_d;
    e_id_q     <= e_id_d;
    e_delay_q  <= e_delay_d;
    e_last_q   <= e_last_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= OUT_W'({e_delay_q, e_id_q, e_status_q, e_kind_q});
      out_last_q <= e_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  // valid bits and the active count move together
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(cnt_q))
    else $error("active count differs from valid bits");

  // an insert always targets a free slot
  a_ins_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS_PUT |-> !valid_q[new_id_q])
    else $error("insert into an occupied slot");

  // a reply is never loaded over one still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("reply register overwritten");

  // a fired item without last is followed by more walking, never by idle
  a_fire_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !e_last_q) |=> state_q == S_RM_RD)
    else $error("fired chain broken");
`endif

endmodule

### sim/sorted_oneshot_timer_queue_tb.sv
// Testbench: random and directed command streams against a built-in timer queue model.
`timescale 1ns / 1ps

module sorted_oneshot_timer_queue_tb;
  import sotq_pkg::*;

  localparam int unsigned SLOTS = SLOTS_DEF;
  localparam int unsigned TBITS = TIME_BITS_DEF;
  localparam int unsigned IN_W  = 72;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    op_e              op;
    logic [IVL_W-1:0] ivl;
    logic [ID_W-1:0]  tid;
    logic [TBITS-1:0] now;
  } command_t;

  typedef struct packed {
    kind_e              kind;
    logic               status;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delay;
    logic               last;
  } reply_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]   cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata;  // opcode, interval_ms, timer_id, now_ms
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;  // kind, status, result_id, delay_ms
  logic               m_axis_tlast;

  sorted_oneshot_timer_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Model state
  logic             slot_used [SLOTS];
  logic [TBITS:0]   slot_due  [SLOTS];
  logic [ID_W-1:0]  due_order [$];
  logic [CFG_W-1:0] min_ivl, max_ivl, idle_dly;

  command_t cmd_pending [$];
  reply_t   expected_replies [$];
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned errors, cmds_sent, replies_seen, quiet_cycles;
  logic [TBITS-1:0] now_ms;

  // Work out the replies of one accepted command
  function automatic void predict_command(command_t c);
    logic [IVL_W-1:0] ivl;
    logic [TBITS:0]   due;
    int               free_id, pos;
    reply_t           r;
    r = '0;
    r.last = 1'b1;
    case (c.op)
      OP_ADD: begin
        ivl = c.ivl;
        if (ivl < min_ivl) ivl = min_ivl;
        else if (ivl > max_ivl) ivl = max_ivl;
        free_id = -1;
        for (int i = SLOTS - 1; i >= 0; i--) if (!slot_used[i]) free_id = i;
        r.kind = KIND_ADD;
        if (free_id < 0) begin
          r.status = 1'b1;
        end else begin
          due = {1'b0, c.now} + ivl;
          pos = due_order.size();
          for (int i = 0; i < due_order.size(); i++) begin
            if (slot_due[due_order[i]] > due) begin
              pos = i;
              break;
            end
          end
          due_order.insert(pos, free_id[ID_W-1:0]);
          slot_used[free_id] = 1'b1;
          slot_due[free_id] = due;
          r.id = free_id[ID_W-1:0];
        end
        expected_replies.insert(expected_replies.size(), r);
      end
      OP_REMOVE: begin
        r.kind = KIND_REM;
        r.id = c.tid;
        r.status = 1'b1;
        for (int i = 0; i < due_order.size(); i++) begin
          if (due_order[i] == c.tid) begin
            slot_used[c.tid] = 1'b0;
            due_order.delete(i);
            r.status = 1'b0;
            break;
          end
        end
        expected_replies.insert(expected_replies.size(), r);
      end
      OP_QUERY: begin
        r.kind = KIND_DELAY;
        r.delay = idle_dly;
        if (due_order.size() > 0) begin
          due = slot_due[due_order[0]];
          if ({1'b0, c.now} >= due) r.delay = '0;
          else if (due - c.now > DELAY_SAT) r.delay = DELAY_SAT;
          else r.delay = DELAY_W'(due - c.now);
        end
        expected_replies.insert(expected_replies.size(), r);
      end
      default: begin
        // fire everything due, tlast only on the final item
        r.kind = KIND_FIRED;
        r.last = 1'b0;
        while (due_order.size() > 0 && slot_due[due_order[0]] <= {1'b0, c.now}) begin
          r.id = due_order.pop_front();
          slot_used[r.id] = 1'b0;
          r.last = (due_order.size() == 0) || (slot_due[due_order[0]] > {1'b0, c.now});
          expected_replies.insert(expected_replies.size(), r);
        end
      end
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pack_command(command_t c);
    return {1'b0, c.now, c.tid, c.ivl, c.op};
  endfunction

  // Split the bus word back into command fields, opcode in the lowest bits
  function automatic command_t unpack_command(logic [IN_W-1:0] d);
    command_t c;
    c.op  = op_e'(d[1:0]);
    c.ivl = d[17:2];
    c.tid = d[23:18];
    c.now = d[70:24];
    return c;
  endfunction

  // Command driver; prediction happens at the accepting edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_command(unpack_command(s_axis_tdata));
        cmds_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pack_command(cmd_pending.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        replies_seen++;
        got.kind   = kind_e'(m_axis_tdata[1:0]);
        got.status = m_axis_tdata[2];
        got.id     = m_axis_tdata[8:3];
        got.delay  = m_axis_tdata[24:9];
        got.last   = m_axis_tlast;
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual %p", $realtime, got);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (got.kind !== want.kind || got.status !== want.status ||
              got.id !== want.id || got.delay !== want.delay || got.last !== want.last ||
              m_axis_tdata[OUT_W-1:25] !== '0) begin
            $display("%0t: mismatch: expected %p, actual %p (tdata %h)", $realtime, want, got,
                     m_axis_tdata);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with work outstanding but nothing accepted
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cmd_pending.size() == 0 && !s_axis_tvalid && expected_replies.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout with %0d items outstanding", expected_replies.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_cmd(op_e op, logic [IVL_W-1:0] ivl, logic [ID_W-1:0] tid);
    command_t c;
    c.op = op;
    c.ivl = ivl;
    c.tid = tid;
    c.now = now_ms;
    cmd_pending.insert(cmd_pending.size(), c);
  endtask

  // Random mix; time moves forward, remove ids lean to the low (likely used) range
  task automatic queue_random(int unsigned n);
    int unsigned sel;
    logic [IVL_W-1:0] ivl;
    for (int k = 0; k < n; k++) begin
      now_ms = now_ms + $urandom_range(0, 150);
      sel = $urandom_range(0, 99);
      ivl = ($urandom_range(0, 3) == 0) ? IVL_W'($urandom) : IVL_W'($urandom_range(0, 400));
      if (sel < 40) queue_cmd(OP_ADD, ivl, ID_W'($urandom));
      else if (sel < 60)
        queue_cmd(OP_REMOVE, IVL_W'($urandom),
                  ($urandom_range(0, 9) < 7) ? ID_W'($urandom_range(0, 7)) : ID_W'($urandom));
      else if (sel < 78) queue_cmd(OP_QUERY, IVL_W'($urandom), ID_W'($urandom));
      else queue_cmd(OP_PROCESS, IVL_W'($urandom), ID_W'($urandom));
    end
  endtask

  // Wait until the block is idle and nothing is outstanding
  task automatic drain();
    do @(negedge clk_i);
    while (cmd_pending.size() != 0 || s_axis_tvalid || expected_replies.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_MIN_IVL:  min_ivl = value;
      CFG_MAX_IVL:  max_ivl = value;
      CFG_IDLE_DLY: idle_dly = value;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi, logic [CFG_W-1:0] idle);
    write_reg(CFG_MIN_IVL, lo);
    write_reg(CFG_MAX_IVL, hi);
    write_reg(CFG_IDLE_DLY, idle);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_NONE;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    errors = 0;
    cmds_sent = 0;
    replies_seen = 0;
    quiet_cycles = 0;
    now_ms = '0;
    min_ivl = MIN_IVL_RST;
    max_ivl = MAX_IVL_RST;
    idle_dly = IDLE_DLY_RST;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_due[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset registers, clamping, ties, remove miss, empty process
    queue_cmd(OP_QUERY, '0, '0);
    queue_cmd(OP_PROCESS, '0, '0);
    queue_cmd(OP_ADD, 16'h0000, '0);
    queue_cmd(OP_ADD, 16'hFFFF, '0);
    queue_cmd(OP_ADD, 16'd50, '0);
    queue_cmd(OP_ADD, 16'd50, '0);
    queue_cmd(OP_QUERY, '0, '0);
    queue_cmd(OP_REMOVE, '0, 6'd1);
    queue_cmd(OP_REMOVE, '0, 6'd63);
    queue_cmd(OP_REMOVE, '0, 6'd1);
    queue_cmd(OP_ADD, 16'd60, '0);
    now_ms = 47'd49;
    queue_cmd(OP_PROCESS, '0, '0);
    now_ms = 47'd50;
    queue_cmd(OP_PROCESS, '0, '0);
    queue_cmd(OP_QUERY, '0, '0);
    now_ms = 47'd20000;
    queue_cmd(OP_QUERY, '0, '0);
    queue_cmd(OP_PROCESS, '0, '0);
    queue_cmd(OP_QUERY, '0, '0);
    queue_random(30);
    drain();

    // Wide clamp window, idle delay zero, sender idling
    set_regs(16'd1, 16'hFFFF, 16'd0);
    send_idle_pct = 59;
    queue_random(60);
    drain();

    // Inverted clamp window: intervals below 65535 become 65535, 65535 becomes 1; fill the queue past full
    set_regs(16'hFFFF, 16'd1, 16'hFFFF);
    send_idle_pct = 0;
    recv_stall_pct = 59;
    queue_cmd(OP_PROCESS, '0, '0);
    queue_cmd(OP_QUERY, '0, '0);
    for (int i = 0; i < SLOTS + 2; i++) queue_cmd(OP_ADD, IVL_W'($urandom), '0);
    queue_cmd(OP_QUERY, '0, '0);
    queue_cmd(OP_REMOVE, '0, 6'd40);
    queue_cmd(OP_ADD, 16'd0, '0);
    now_ms = now_ms + 47'd65535;
    queue_cmd(OP_PROCESS, '0, '0);
    drain();

    // Narrow window, both sides idling, then time near its top end
    set_regs(16'd1, 16'd300, 16'd1234);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    queue_random(40);
    now_ms = {TBITS{1'b1}} - 47'd100;
    queue_cmd(OP_PROCESS, '0, '0);
    queue_cmd(OP_ADD, 16'd300, '0);
    queue_cmd(OP_ADD, 16'd50, '0);
    now_ms = {TBITS{1'b1}};
    queue_cmd(OP_QUERY, '0, '0);
    queue_cmd(OP_PROCESS, '0, '0);
    queue_cmd(OP_QUERY, '0, '0);
    drain();

    $display("Sent %0d commands, checked %0d replies over four register settings,",
             cmds_sent, replies_seen);
    $display("including a full queue, clamp extremes and time at its upper limit.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
